@@ hw/rtl/csmm_pkg.sv @@
// Package for the min/max contrast stretch block.
// Holds pixel width, tracker reset values, gray scale constants and helpers.
// No dependencies.
package csmm_pkg;

	localparam int PIXEL_BITS = 16;
	localparam int IN_BITS    = 16;
	localparam int GRAY_BITS  = 8;
	localparam int DIV_STEPS  = GRAY_BITS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS);

	localparam logic signed [IN_BITS-1:0] LOW_RESET  = 16'sh7FFF;
	localparam logic signed [IN_BITS-1:0] HIGH_RESET = 16'sh8000;
	localparam logic [GRAY_BITS-1:0]      GRAY_TOP   = 8'd255;
	localparam logic [GRAY_BITS-1:0]      GRAY_ZERO  = 8'd0;

	localparam logic OP_GATHER = 1'b0;
	localparam logic OP_MAP    = 1'b1;

	// low PIXEL_BITS bits read as two's complement
	function automatic logic signed [IN_BITS-1:0] pixel_value(input logic [IN_BITS-1:0] raw);
		logic signed [PIXEL_BITS-1:0] v;
		v = raw[PIXEL_BITS-1:0];
		return IN_BITS'(v);
	endfunction

endpackage

@@ hw/rtl/contrast_stretch_min_max_top.sv @@
// Min/max contrast stretch of signed gray values into 0..255.
// Uses csmm_pkg for widths, constants and pixel decoding.
//
// Usage:
//   Input channel (in_valid/in_ready) carries op, pixel and first. The host
//   streams the image twice: op=0 items gather the running min and max
//   (first=1 restarts both trackers on that pixel) and give no result; op=1
//   items each give one result on the output channel (out_valid/out_ready):
//   stretched = 255*(p-min)/(max-min) truncated, clipped when p lies outside
//   the gathered range (saturated to 0 or 255). A flat range maps to 0, an
//   empty range (no gather since reset) gives 0 and no clip.
// Sequence:
//   A gather item only updates the trackers and leaves the block ready. A
//   map item passes capture, offset/scale/classify and the output register
//   load; unless the pixel saturates or the range is flat or empty, 8 steps
//   of a shared restoring subtract-compare unit, one quotient bit each, come
//   before that load. in_ready is low while a map item is in work.
// Stall:
//   The result sits in an output register; the block goes back to taking
//   items while it waits. A second result waits in the sequencer until the
//   output register frees.
// Reset: arst_n clears control, min tracker to 32767, max tracker to -32768.
module contrast_stretch_min_max_top
	import csmm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [IN_BITS-1:0]   pixel,
	input  logic                 first,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [GRAY_BITS-1:0] stretched,
	output logic                 clipped
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_EMIT
	} state_t;

	state_t                      state_q;
	logic signed [IN_BITS-1:0]   low_q;
	logic signed [IN_BITS-1:0]   high_q;
	logic signed [IN_BITS-1:0]   pix_q;
	logic [IN_BITS-1:0]          span_q;
	logic [IN_BITS-1:0]          rem_q;
	logic [GRAY_BITS-1:0]        num_q;
	logic [STEP_BITS-1:0]        step_q;
	logic [GRAY_BITS-1:0]        res_q;
	logic                        clip_q;
	logic                        out_valid_q;
	logic [GRAY_BITS-1:0]        stretched_q;
	logic                        clipped_q;

	logic signed [IN_BITS-1:0]   pix_in;
	logic signed [IN_BITS:0]     offset;
	logic signed [IN_BITS:0]     span;
	logic [IN_BITS+GRAY_BITS-1:0] scaled;
	logic [IN_BITS:0]            trial_rem;
	logic [IN_BITS:0]            trial;
	logic                        qbit;
	logic                        in_acc;
	logic                        out_free;

	assign pix_in   = pixel_value(pixel);
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign offset = IN_BITS'(0) + ({pix_q[IN_BITS-1], pix_q} - {low_q[IN_BITS-1], low_q});
	assign span   = {high_q[IN_BITS-1], high_q} - {low_q[IN_BITS-1], low_q};
	// 255*offset = (offset << 8) - offset
	assign scaled = {offset[IN_BITS-1:0], GRAY_BITS'(0)}
		- {GRAY_BITS'(0), offset[IN_BITS-1:0]};

	assign trial_rem = {rem_q, num_q[GRAY_BITS-1]};
	assign trial     = trial_rem - {1'b0, span_q};
	assign qbit      = (trial_rem >= {1'b0, span_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_q       <= LOW_RESET;
			high_q      <= HIGH_RESET;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_EMIT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (op == OP_MAP) begin
							pix_q   <= pix_in;
							state_q <= S_PREP;
						end else if (first) begin
							low_q  <= pix_in;
							high_q <= pix_in;
						end else begin
							if (pix_in < low_q)
								low_q <= pix_in;
							if (pix_in > high_q)
								high_q <= pix_in;
						end
					end
				end
				S_PREP: begin
					if (high_q < low_q) begin
						res_q   <= GRAY_ZERO;
						clip_q  <= 1'b0;
						state_q <= S_EMIT;
					end else if (high_q == low_q) begin
						res_q   <= GRAY_ZERO;
						clip_q  <= (pix_q != low_q);
						state_q <= S_EMIT;
					end else if (pix_q < low_q) begin
						res_q   <= GRAY_ZERO;
						clip_q  <= 1'b1;
						state_q <= S_EMIT;
					end else if (pix_q > high_q) begin
						res_q   <= GRAY_TOP;
						clip_q  <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						// quotient fits 8 bits, so the top 16 bits start below span
						span_q  <= span[IN_BITS-1:0];
						rem_q   <= scaled[IN_BITS+GRAY_BITS-1:GRAY_BITS];
						num_q   <= scaled[GRAY_BITS-1:0];
						clip_q  <= 1'b0;
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= qbit ? trial[IN_BITS-1:0] : trial_rem[IN_BITS-1:0];
					num_q  <= {num_q[GRAY_BITS-2:0], qbit};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
						res_q   <= {num_q[GRAY_BITS-2:0], qbit};
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						stretched_q <= res_q;
						clipped_q   <= clip_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign stretched = stretched_q;
	assign clipped   = clipped_q;

	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_MAP) |=> !in_ready)
		else $error("map item did not block input");

	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (span_q != '0) && (rem_q < span_q))
		else $error("divider remainder out of range");

	a_gather_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_GATHER) |=> (low_q <= high_q))
		else $error("trackers out of order after gather");

	a_emit_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && out_free |=> out_valid && (state_q == S_IDLE))
		else $error("result not loaded into output register");

endmodule

@@ tb/tb.sv @@
// Testbench for contrast_stretch_min_max_top: directed and random gather/map
// passes, checked against a built-in min/max stretch predictor.
// Depends on csmm_pkg and the RTL top level.
module tb;
	import csmm_pkg::*;

	typedef struct {
		logic               op;
		logic [IN_BITS-1:0] pixel;
		logic               first;
	} pixel_item_t;

	typedef struct {
		logic [GRAY_BITS-1:0] stretched;
		logic                 clipped;
	} gray_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 op = OP_GATHER;
	logic [IN_BITS-1:0]   pixel = '0;
	logic                 first = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [GRAY_BITS-1:0] stretched;
	logic                 clipped;

	pixel_item_t  pending_items[$];
	gray_result_t expected_grays[$];
	gray_result_t got_want;
	pixel_item_t  next_item;

	logic signed [IN_BITS-1:0] min_track = LOW_RESET;
	logic signed [IN_BITS-1:0] max_track = HIGH_RESET;

	int  total_items = 0;
	int  items_accepted = 0;
	int  mismatches = 0;
	int  send_gap = 0;
	int  recv_stall = 0;
	int  hold_left = 0;
	int  holds_done = 0;
	bit  noisy = 1'b1;
	bit  calm;
	bit  offering;

	contrast_stretch_min_max_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.pixel     (pixel),
		.first     (first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stretched (stretched),
		.clipped   (clipped)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	function automatic int rand_in(int a, int b);
		return a + int'($urandom_range(0, b - a));
	endfunction

	function automatic void add_item(logic o, int pix, logic fst);
		pixel_item_t it;
		it.op = o;
		it.pixel = pix[IN_BITS-1:0];
		it.first = fst;
		pending_items.push_back(it);
	endfunction

	// update trackers on a gather item, queue the expected result on a map item
	function automatic void track_and_stretch(pixel_item_t it);
		logic signed [PIXEL_BITS-1:0] narrow;
		logic signed [IN_BITS-1:0]    p;
		gray_result_t                 r;
		int                           offset;
		int                           span;
		narrow = it.pixel[PIXEL_BITS-1:0];
		p = narrow;
		if (it.op == OP_GATHER) begin
			if (it.first) begin
				min_track = p;
				max_track = p;
			end else begin
				if (p < min_track)
					min_track = p;
				if (p > max_track)
					max_track = p;
			end
			return;
		end
		r.stretched = GRAY_ZERO;
		r.clipped = 1'b0;
		if (max_track == min_track) begin
			r.clipped = (p != min_track);
		end else if (max_track > min_track) begin
			if (p < min_track) begin
				r.clipped = 1'b1;
			end else if (p > max_track) begin
				r.stretched = GRAY_TOP;
				r.clipped = 1'b1;
			end else begin
				offset = int'(p) - int'(min_track);
				span = int'(max_track) - int'(min_track);
				r.stretched = 8'((255 * offset) / span);
			end
		end
		expected_grays.push_back(r);
	endfunction

	// stimulus
	initial begin
		int lo;
		int hi;
		int span;
		int n;
		int k;
		int pick;
		// empty range since reset
		add_item(OP_MAP, 0, 1'b0);
		add_item(OP_MAP, -32768, 1'b1);
		// flat range
		add_item(OP_GATHER, 100, 1'b1);
		add_item(OP_MAP, 100, 1'b0);
		add_item(OP_MAP, 99, 1'b0);
		add_item(OP_MAP, 101, 1'b0);
		// full range extremes
		add_item(OP_GATHER, -32768, 1'b0);
		add_item(OP_GATHER, 32767, 1'b0);
		add_item(OP_MAP, -32768, 1'b0);
		add_item(OP_MAP, 32767, 1'b0);
		add_item(OP_MAP, 0, 1'b0);
		add_item(OP_MAP, -1, 1'b0);
		// small range, below / above / inside
		add_item(OP_GATHER, 10, 1'b1);
		add_item(OP_GATHER, 20, 1'b0);
		add_item(OP_GATHER, 15, 1'b0);
		add_item(OP_MAP, 5, 1'b0);
		add_item(OP_MAP, 25, 1'b0);
		add_item(OP_MAP, 10, 1'b0);
		add_item(OP_MAP, 20, 1'b0);
		add_item(OP_MAP, 15, 1'b0);
		add_item(OP_MAP, 12, 1'b1);
		// restart drops the old range
		add_item(OP_GATHER, -5, 1'b1);
		add_item(OP_GATHER, -6, 1'b0);
		add_item(OP_MAP, -5, 1'b0);
		add_item(OP_MAP, 32767, 1'b0);

		while (pending_items.size() < 1000) begin
			if ($urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					add_item(1'($urandom), int'($urandom_range(0, 65535)), 1'($urandom));
			end else begin
				pick = $urandom_range(0, 3);
				case (pick)
					0: span = 0;
					1: span = $urandom_range(1, 20);
					2: span = $urandom_range(21, 2000);
					default: span = $urandom_range(2001, 65535);
				endcase
				lo = rand_in(-32768, 32767 - span);
				hi = lo + span;
				n = $urandom_range(1, 12);
				for (k = 0; k < n; k++) begin
					if (k == 0)
						add_item(OP_GATHER, lo, ($urandom_range(0, 7) != 0));
					else if (k == n - 1)
						add_item(OP_GATHER, hi, 1'b0);
					else
						add_item(OP_GATHER, rand_in(lo, hi), 1'b0);
				end
				n = $urandom_range(1, 12);
				for (k = 0; k < n; k++) begin
					pick = $urandom_range(0, 11);
					if (pick == 0)
						add_item(OP_MAP, lo, 1'($urandom));
					else if (pick == 1)
						add_item(OP_MAP, hi, 1'($urandom));
					else if (pick < 4)
						add_item(OP_MAP, int'($urandom_range(0, 65535)), 1'($urandom));
					else
						add_item(OP_MAP, rand_in(lo, hi), 1'($urandom));
				end
			end
		end
		total_items = pending_items.size();

		wait (arst_n === 1'b1);
		while (items_accepted < total_items || expected_grays.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	always @(posedge clk)
		calm <= (pending_items.size() < 100);

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offering = in_valid;
			if (in_valid && in_ready) begin
				next_item.op = op;
				next_item.pixel = pixel;
				next_item.first = first;
				track_and_stretch(next_item);
				items_accepted++;
				offering = 1'b0;
				if ($urandom_range(0, 39) == 0)
					noisy = ~noisy;
				if (noisy && !calm && $urandom_range(0, 3) == 0)
					send_gap = $urandom_range(1, 4);
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					next_item = pending_items.pop_front();
					op <= next_item.op;
					pixel <= next_item.pixel;
					first <= next_item.first;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure, with two long hold-offs to fill the block
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_done < 2 && items_accepted >= 300 * (holds_done + 1)) begin
			holds_done <= holds_done + 1;
			hold_left <= 250;
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall <= recv_stall - 1;
			out_ready <= 1'b0;
		end else if (noisy && !calm && $urandom_range(0, 4) == 0) begin
			recv_stall <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_grays.size() == 0) begin
				$display("%0t: unexpected result stretched %0d clipped %0d",
					$time, stretched, clipped);
				mismatches++;
			end else begin
				got_want = expected_grays.pop_front();
				if (stretched !== got_want.stretched) begin
					$display("%0t: stretched expected %0d actual %0d",
						$time, got_want.stretched, stretched);
					mismatches++;
				end
				if (clipped !== got_want.clipped) begin
					$display("%0t: clipped expected %0d actual %0d",
						$time, got_want.clipped, clipped);
					mismatches++;
				end
			end
		end
	end

endmodule
